### hdl/bfa_pkg.sv
// Shared types and constants for the block fit allocator.
// No dependencies; imported by every module of the block.
package bfa_pkg;

  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned IdxW      = $clog2(MaxBlocks);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned NumW      = CntW;
  localparam int unsigned SizeW     = 16;
  localparam int unsigned DataW     = 32;
  localparam int unsigned AddrW     = 3;

  // word index of the policy register
  localparam logic RegFitPolicy = 1'b0;

  typedef enum logic [1:0] {
    KindLoad    = 2'd0,
    KindRequest = 2'd1,
    KindRewind  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PolFirst = 2'd0,
    PolBest  = 2'd1,
    PolWorst = 2'd2,
    PolNext  = 2'd3
  } policy_e;

  typedef struct packed {
    kind_e              kind;
    logic [SizeW-1:0]   size;
  } cmd_t;

endpackage

### hdl/bfa_front.sv
// Front end: accepts input items, drops unused kinds, and holds
// classified commands in a two-entry queue. Depends on bfa_pkg.
module bfa_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic [1:0]               kind_i,
  input  logic [bfa_pkg::SizeW-1:0] size_value_i,
  output logic                     cmd_vld_o,
  output bfa_pkg::cmd_t            cmd_o,
  input  logic                     cmd_pop_i
);
  import bfa_pkg::*;

  cmd_t       queue_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic       kind_ok, keep, pop;

  always_comb begin
    unique case (kind_i) inside
      KindLoad, KindRequest, KindRewind: kind_ok = 1'b1;
      default:                           kind_ok = 1'b0;
    endcase
  end

  assign full_o    = (cnt_q == 2'd2);
  assign cmd_vld_o = (cnt_q != 2'd0);
  assign cmd_o     = queue_q[rd_q];
  assign keep      = push_i && !full_o && kind_ok;
  assign pop       = cmd_pop_i && cmd_vld_o;
  assign cnt_d     = cnt_q + {1'b0, keep} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (keep) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      queue_q[wr_q].kind <= kind_e'(kind_i);
      queue_q[wr_q].size <= size_value_i;
    end
  end

endmodule

### hdl/bfa_back.sv
// Back end: block size table, taken bits, and the sequential fit search.
// One block is read and compared per cycle. Depends on bfa_pkg.
module bfa_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bfa_pkg::policy_e          policy_i,
  input  logic                      cmd_vld_i,
  input  bfa_pkg::cmd_t             cmd_i,
  output logic                      cmd_pop_o,
  output logic                      res_empty_o,
  input  logic                      res_pop_i,
  output logic [bfa_pkg::NumW-1:0]  block_number_o,
  output logic [bfa_pkg::SizeW-1:0] leftover_o
);
  import bfa_pkg::*;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StScan   = 3'b010,
    StFinish = 3'b100
  } back_state_e;

  back_state_e state_q;

  logic [SizeW-1:0] sizes_mem [MaxBlocks];
  logic [MaxBlocks-1:0] taken_q;
  logic [CntW-1:0]  count_q;
  logic [IdxW-1:0]  next_q;

  logic [IdxW-1:0]  rd_idx_q, cmp_idx_q, pos_q, start_idx, rd_idx_nxt;
  logic [CntW-1:0]  rem_q, pos_inc;
  logic             cmp_vld_q, cmp_last_q, found_q;
  logic [SizeW-1:0] rd_data_q, req_q, best_q, diff;
  logic             issue, fits, take, mem_we, slot_free;
  logic             out_vld_q;
  logic [NumW-1:0]  out_num_q;
  logic [SizeW-1:0] out_left_q;

  assign cmd_pop_o  = (state_q == StIdle) && cmd_vld_i;
  assign mem_we     = cmd_pop_o && (cmd_i.kind == KindLoad) &&
                      (count_q < CntW'(MaxBlocks));
  assign start_idx  = (policy_i == PolNext && {1'b0, next_q} < count_q) ? next_q : '0;
  assign issue      = (state_q == StScan) && (rem_q != '0);
  // cyclic step through the stored blocks
  assign rd_idx_nxt = ({1'b0, rd_idx_q} + CntW'(1) >= count_q) ? '0 : rd_idx_q + IdxW'(1);

  assign diff = rd_data_q - req_q;
  assign fits = !taken_q[cmp_idx_q] && (rd_data_q >= req_q);
  // strict compares keep the lowest index on ties
  assign take = cmp_vld_q && fits &&
                (!found_q || (policy_i == PolBest && diff < best_q) ||
                 (policy_i == PolWorst && diff > best_q));

  assign pos_inc   = {1'b0, pos_q} + CntW'(1);
  assign slot_free = !out_vld_q || res_pop_i;

  assign res_empty_o    = !out_vld_q;
  assign block_number_o = out_num_q;
  assign leftover_o     = out_left_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) sizes_mem[count_q[IdxW-1:0]] <= cmd_i.size;
    rd_data_q <= sizes_mem[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      taken_q    <= '0;
      count_q    <= '0;
      next_q     <= '0;
      cmp_vld_q  <= 1'b0;
      found_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      cmp_vld_q <= issue;
      if (state_q == StFinish && slot_free) out_vld_q <= 1'b1;
      else if (res_pop_i)                  out_vld_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (cmd_pop_o) begin
            unique case (cmd_i.kind)
              KindLoad: begin
                if (mem_we) begin
                  taken_q[count_q[IdxW-1:0]] <= 1'b0;
                  count_q <= count_q + CntW'(1);
                end
              end
              KindRequest: begin
                found_q <= 1'b0;
                state_q <= (count_q == '0) ? StFinish : StScan;
              end
              KindRewind: begin
                taken_q <= '0;
                next_q  <= '0;
              end
              default: ;
            endcase
          end
        end
        StScan: begin
          if (take) found_q <= 1'b1;
          if (cmp_vld_q && cmp_last_q) state_q <= StFinish;
        end
        StFinish: begin
          if (slot_free) begin
            if (found_q) begin
              taken_q[pos_q] <= 1'b1;
              if (policy_i == PolNext) next_q <= (pos_inc >= count_q) ? '0 : pos_inc[IdxW-1:0];
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // search datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.kind == KindRequest) begin
      req_q    <= cmd_i.size;
      rem_q    <= count_q;
      rd_idx_q <= start_idx;
    end else if (issue) begin
      rem_q    <= rem_q - CntW'(1);
      rd_idx_q <= rd_idx_nxt;
    end
    cmp_idx_q  <= rd_idx_q;
    cmp_last_q <= (rem_q == CntW'(1));
    if (state_q == StScan && take) begin
      pos_q  <= cmp_idx_q;
      best_q <= diff;
    end
    if (state_q == StFinish && slot_free) begin
      out_num_q  <= found_q ? pos_inc : '0;
      out_left_q <= found_q ? best_q : '0;
    end
  end

endmodule

### hdl/block_fit_allocator_unit.sv
// Block fit allocator: load and rewind items are handled directly in the idle state.
// A request's result comes from a one-block-per-cycle scan over the single-port size
// table (skipped on an empty table) and waits in an output register until popped.
// Up to two items queue ahead of the search while a result waits.
// Reset is asynchronous, active low; all state clears at once, no clearing pass.
module block_fit_allocator_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bfa_pkg::AddrW-1:0] paddr,
  input  logic [bfa_pkg::DataW-1:0] pwdata,
  output logic [bfa_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                kind_i,
  input  logic [bfa_pkg::SizeW-1:0] size_value_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [bfa_pkg::NumW-1:0]  block_number_o,
  output logic [bfa_pkg::SizeW-1:0] leftover_o
);
  // Depends on bfa_pkg, bfa_front and bfa_back.
  import bfa_pkg::*;

  policy_e policy_q;
  logic    reg_hit;
  logic    cmd_vld, cmd_pop;
  cmd_t    cmd;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[AddrW-1] == RegFitPolicy);
  assign prdata  = reg_hit ? {{(DataW-2){1'b0}}, policy_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= PolFirst;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      policy_q <= policy_e'(pwdata[1:0]);
    end
  end

  bfa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .kind_i       (kind_i),
    .size_value_i (size_value_i),
    .cmd_vld_o    (cmd_vld),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  bfa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .policy_i       (policy_q),
    .cmd_vld_i      (cmd_vld),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .res_empty_o    (empty),
    .res_pop_i      (pop),
    .block_number_o (block_number_o),
    .leftover_o     (leftover_o)
  );

endmodule

### tb/tb_top.sv
// Self-checking bench for block_fit_allocator_unit: a directed table, then random
// load/request/rewind traffic under all four fit policies, checked by a local allocator model.
// Depends on bfa_pkg and the block's RTL; reads no files.
module tb_top;
  import bfa_pkg::*;

  localparam logic [1:0]       KindUnused  = 2'd3;
  localparam logic [AddrW-1:0] PolicyAddr  = AddrW'(4 * int'(RegFitPolicy));
  localparam int               RandItems   = 1875;
  localparam int               SegItems    = 150;
  localparam int               DrainCycles = MaxBlocks + 16;  // longest request plus queued items
  localparam int               StallLimit  = 4000;

  typedef struct packed {
    logic [NumW-1:0]  num;
    logic [SizeW-1:0] left;
  } grant_t;

  typedef struct packed {
    bit               is_cfg;
    policy_e          pol;
    logic [1:0]       kind;
    logic [SizeW-1:0] size;
    bit               has_exp;
    grant_t           exp;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              push = 1'b0;
  logic              full;
  logic [1:0]        kind_i = KindLoad;
  logic [SizeW-1:0]  size_value_i = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [NumW-1:0]   block_number_o;
  logic [SizeW-1:0]  leftover_o;

  block_fit_allocator_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .push           (push),
    .full           (full),
    .kind_i         (kind_i),
    .size_value_i   (size_value_i),
    .empty          (empty),
    .pop            (pop),
    .block_number_o (block_number_o),
    .leftover_o     (leftover_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // allocator model state
  logic [SizeW-1:0] blk_size [MaxBlocks];
  bit               blk_taken [MaxBlocks];
  int unsigned      blk_count = 0;
  int unsigned      nf_start = 0;
  policy_e          cur_policy = PolFirst;

  grant_t      pending_grants [$];
  bit          pend_has_exp = 1'b0;
  grant_t      pend_exp = '0;
  int          items_in = 0;
  int          errors = 0;
  int          stall_cycles = 0;
  int          send_idle = 16;
  int          recv_idle = 54;
  int          n_req = 0, n_grant = 0, n_load = 0, n_dropped = 0, n_rewind = 0;
  bit [3:0]    pol_seen = '0;

  task automatic log_fail(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch @%0t: %s", $time, msg);
  endtask

  // Applies one item to the model; returns 1 when the item yields a result.
  function automatic bit predict_item(input logic [1:0] kind, input logic [SizeW-1:0] size,
                                      output grant_t res);
    int unsigned j, pos, best, d;
    bit          found;
    res = '0;
    found = 1'b0;
    pos = 0;
    best = 0;
    if (kind == KindLoad) begin
      if (blk_count < MaxBlocks) begin
        blk_size[blk_count] = size;
        blk_taken[blk_count] = 1'b0;
        blk_count++;
        n_load++;
      end else begin
        n_dropped++;
      end
      return 1'b0;
    end
    if (kind == KindRewind) begin
      for (int i = 0; i < MaxBlocks; i++) blk_taken[i] = 1'b0;
      nf_start = 0;
      n_rewind++;
      return 1'b0;
    end
    if (kind != KindRequest) return 1'b0;

    n_req++;
    pol_seen[cur_policy] = 1'b1;
    if (cur_policy == PolNext) begin
      j = (nf_start < blk_count) ? nf_start : 0;
      for (int i = 0; i < blk_count; i++) begin
        if (!blk_taken[j] && blk_size[j] >= size) begin
          found = 1'b1;
          pos = j;
          break;
        end
        j++;
        if (j >= blk_count) j = 0;
      end
      if (found) nf_start = (pos + 1 >= blk_count) ? 0 : pos + 1;
    end else begin
      for (int i = 0; i < blk_count; i++) begin
        if (blk_taken[i] || blk_size[i] < size) continue;
        d = blk_size[i] - size;
        if (!found || (cur_policy == PolBest && d < best) ||
            (cur_policy == PolWorst && d > best)) begin
          found = 1'b1;
          pos = i;
          best = d;
          if (cur_policy == PolFirst) break;
        end
      end
    end
    if (found) begin
      blk_taken[pos] = 1'b1;
      res.num = NumW'(pos + 1);
      res.left = blk_size[pos] - size;
      n_grant++;
    end
    return 1'b1;
  endfunction

  // Edge monitor: register writes, accepted items, accepted results, stall watchdog.
  always @(posedge clk_i) begin
    grant_t want, got;
    bit     has;
    bit     moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (psel && penable && pwrite && pready && paddr == PolicyAddr)
        cur_policy = policy_e'(pwdata[1:0]);
      if (push && !full) begin
        moved = 1'b1;
        items_in++;
        has = predict_item(kind_i, size_value_i, want);
        if (has) begin
          if (pend_has_exp) want = pend_exp;
          pending_grants.push_back(want);
        end
      end
      if (pop && !empty) begin
        moved = 1'b1;
        got.num = block_number_o;
        got.left = leftover_o;
        if (pending_grants.size() == 0) begin
          log_fail($sformatf("unexpected result block=%0d leftover=%0d", got.num, got.left));
        end else begin
          want = pending_grants.pop_front();
          if (got.num !== want.num)
            log_fail($sformatf("block_number exp %0d got %0d", want.num, got.num));
          if (got.left !== want.left)
            log_fail($sformatf("leftover exp %0d got %0d", want.left, got.left));
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                 StallLimit, pending_grants.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  always @(negedge clk_i) pop <= rst_ni && ($urandom_range(99) >= recv_idle);

  // Called at a falling edge; returns at the falling edge after the item is taken.
  // push is left high so back-to-back items need no extra toggle.
  task automatic send_item(input logic [1:0] kind, input logic [SizeW-1:0] size);
    int target;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    kind_i <= kind;
    size_value_i <= size;
    target = items_in + 1;
    do @(negedge clk_i); while (items_in != target);
  endtask

  // Drains the block, writes the policy, then reads it back.
  task automatic set_policy(input policy_e pol);
    push <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PolicyAddr;
    pwdata <= DataW'(pol);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[1:0] !== pol)
      log_fail($sformatf("fit_policy readback exp %0d got %0d", pol, prdata[1:0]));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic dir_row_t op_row(input logic [1:0] kind, input logic [SizeW-1:0] size);
    op_row = '0;
    op_row.kind = kind;
    op_row.size = size;
  endfunction

  function automatic dir_row_t chk_row(input logic [SizeW-1:0] size, input logic [NumW-1:0] num,
                                       input logic [SizeW-1:0] left);
    chk_row = op_row(KindRequest, size);
    chk_row.has_exp = 1'b1;
    chk_row.exp.num = num;
    chk_row.exp.left = left;
  endfunction

  function automatic dir_row_t cfg_row(input policy_e pol);
    cfg_row = '0;
    cfg_row.is_cfg = 1'b1;
    cfg_row.pol = pol;
  endfunction

  function automatic logic [SizeW-1:0] pick_block_size();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 50) return SizeW'($urandom);
    return SizeW'($urandom_range(1023));
  endfunction

  // Mostly sizes near a stored block so grants, ties and near misses are common.
  function automatic logic [SizeW-1:0] pick_request_size();
    int               r;
    logic [SizeW-1:0] base;
    r = $urandom_range(99);
    if (r < 10 || blk_count == 0) return '0;
    if (r < 25) return SizeW'($urandom);
    if (r < 35) return SizeW'($urandom_range(255));
    base = blk_size[$urandom_range(blk_count - 1)];
    if (r < 55) return base;
    if (r < 65) return base + 1'b1;
    return (base > 16) ? base - SizeW'($urandom_range(16)) : SizeW'($urandom_range(base));
  endfunction

  initial begin
    dir_row_t         rows [$];
    int               n, seg, cur_seg, r;
    logic [1:0]       kind;
    logic [SizeW-1:0] size;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty table, ignored kind, extremes of size, every policy
    rows.push_back(chk_row(16'd0, 7'd0, 16'd0));        // empty table refuses
    rows.push_back(op_row(KindRewind, 16'hFFFF));
    rows.push_back(op_row(KindUnused, 16'hFFFF));
    rows.push_back(op_row(KindLoad, 16'hFFFF));
    rows.push_back(op_row(KindLoad, 16'd0));
    rows.push_back(op_row(KindLoad, 16'd100));
    rows.push_back(op_row(KindLoad, 16'd60));
    rows.push_back(op_row(KindLoad, 16'd100));
    rows.push_back(chk_row(16'd0, 7'd1, 16'hFFFF));     // zero size fits the first block
    rows.push_back(chk_row(16'hFFFF, 7'd0, 16'd0));     // largest block already taken
    rows.push_back(op_row(KindRequest, 16'd60));
    rows.push_back(cfg_row(PolBest));
    rows.push_back(op_row(KindRewind, 16'd0));
    rows.push_back(op_row(KindRequest, 16'd60));
    rows.push_back(op_row(KindRequest, 16'd100));       // tie between equal blocks
    rows.push_back(cfg_row(PolWorst));
    rows.push_back(op_row(KindRequest, 16'd1));
    rows.push_back(op_row(KindRequest, 16'd50));
    rows.push_back(cfg_row(PolNext));
    rows.push_back(op_row(KindRewind, 16'd0));
    repeat (5) rows.push_back(op_row(KindRequest, 16'd50));  // walks around and wraps
    rows.push_back(op_row(KindRequest, 16'd0));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        set_policy(rows[i].pol);
      end else begin
        pend_has_exp = rows[i].has_exp;
        pend_exp = rows[i].exp;
        send_item(rows[i].kind, rows[i].size);
        pend_has_exp = 1'b0;
      end
    end

    // random: policy changes per segment, idle profile changes per third
    n = 0;
    cur_seg = -1;
    while (n < RandItems) begin
      seg = n / SegItems;
      if (seg != cur_seg) begin
        cur_seg = seg;
        set_policy(policy_e'(seg % 4));
      end
      case ((n * 3) / RandItems)
        0: begin
          send_idle = 16;
          recv_idle = 54;
        end
        1: begin
          send_idle = 54;
          recv_idle = 16;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      r = $urandom_range(99);
      if (r < 8) begin
        kind = KindLoad;
        size = pick_block_size();
      end else if (r < 18) begin
        kind = KindRewind;
        size = SizeW'($urandom);
      end else if (r < 20) begin
        kind = KindUnused;
        size = SizeW'($urandom);
      end else begin
        kind = KindRequest;
        size = pick_request_size();
      end
      n++;
      send_item(kind, size);
    end

    push <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("covered %0d requests (%0d granted), %0d loads (%0d dropped on a full table),",
             n_req, n_grant, n_load, n_dropped);
    $display("%0d rewinds; policies seen %b, table holds %0d of %0d blocks, %0d mismatches",
             n_rewind, pol_seen, blk_count, MaxBlocks, errors);
    if (errors == 0 && pending_grants.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### block_fit_allocator_unit.f
hdl/bfa_pkg.sv
hdl/bfa_front.sv
hdl/bfa_back.sv
hdl/block_fit_allocator_unit.sv
tb/tb_top.sv
